[src/fts_pkg.sv]
// Shared types and constants for the fixed timestep scheduler.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package fts_pkg;

   parameter int unsigned TIME_W              = 64;
   parameter int unsigned FIXED_W             = 32;
   parameter int unsigned ITER_W              = 3;
   parameter int unsigned MAX_UPDATES_DEFAULT = 4;

   parameter logic [FIXED_W-1:0] FIXED_STEP_RESET = 32'd16666;

   parameter logic CMD_QUERY   = 1'b0;
   parameter logic CMD_ADVANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CHECK,
      ST_DIV,
      ST_CEIL,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_FIXED,
      PH_MAX,
      PH_STEP
   } phase_type;

endpackage

[src/fts_req_if.sv]
// Request channel of the fixed timestep scheduler: valid/ready and one item.
// Depends on fts_pkg for field widths.
`timescale 1ns / 1ps

interface fts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [fts_pkg::TIME_W-1:0]  current_time;
   logic [fts_pkg::TIME_W-1:0]  advance_step;

   modport source (output valid, output command, output current_time,
                   output advance_step, input ready);
   modport sink   (input valid, input command, input current_time,
                   input advance_step, output ready);
endinterface

[src/fts_rsp_if.sv]
// Response channel of the fixed timestep scheduler: valid/ready and one item.
// Depends on fts_pkg for field widths.
`timescale 1ns / 1ps

interface fts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fts_pkg::ITER_W-1:0]  iterations;
   logic [fts_pkg::TIME_W-1:0]  step_us;

   modport source (output valid, output iterations, output step_us, input ready);
   modport sink   (input valid, input iterations, input step_us, output ready);
endinterface

[src/fixed_timestep_scheduler.sv]
// An advance or first query goes straight to the finish state; a query not due leaves
// from the diff or check state; a query due does one division, three when the step is
// stretched. A bit-serial restoring divider does each, one quotient bit per cycle.
// One item at a time; the next is taken as soon as the result moves to the output
// register, even while that result still waits to be taken.
// Reset (synchronous): fixed step 16666 us, last update time 0, first query pending.
`timescale 1ns / 1ps

module fixed_timestep_scheduler #(
   parameter int unsigned MAX_UPDATES = fts_pkg::MAX_UPDATES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [fts_pkg::FIXED_W-1:0]   csr_wr_data,
   fts_req_if.sink                       req_ch,
   fts_rsp_if.source                     rsp_ch
);

   localparam int unsigned TW    = fts_pkg::TIME_W;
   localparam int unsigned FW    = fts_pkg::FIXED_W;
   localparam int unsigned IW    = fts_pkg::ITER_W;
   localparam int unsigned CNT_W = $clog2(TW);
   localparam logic [TW-1:0] MAX_DIV = TW'(MAX_UPDATES);

   fts_pkg::state_type state_ff, state_in;
   fts_pkg::phase_type phase_ff, phase_in;

   logic            first_ff, first_in;
   logic [FW-1:0]   fixed_ff, fixed_in;
   logic [TW-1:0]   last_ff, last_in;
   logic [TW-1:0]   now_ff, now_in;
   logic [TW-1:0]   amount_ff, amount_in;
   logic [TW-1:0]   quo_ff, quo_in;
   logic [TW-1:0]   rem_ff, rem_in;
   logic [TW-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TW-1:0]   ceil_ff, ceil_in;
   logic [IW-1:0]   res_iter_ff, res_iter_in;
   logic [TW-1:0]   res_step_ff, res_step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]   out_iter_ff, out_iter_in;
   logic [TW-1:0]   out_step_ff, out_step_in;

   logic [TW-1:0]   f_eff;
   logic [TW:0]     time_diff;
   logic [TW:0]     rem_sh;
   logic [TW:0]     rem_sub;

   assign f_eff     = (fixed_ff == '0) ? TW'(1) : TW'(fixed_ff);
   assign time_diff = {1'b0, now_ff} - {1'b0, last_ff};
   assign rem_sh    = {rem_ff, quo_ff[TW-1]};
   assign rem_sub   = rem_sh - {1'b0, den_ff};

   assign req_ch.ready      = (state_ff == fts_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.iterations = out_iter_ff;
   assign rsp_ch.step_us    = out_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::ST_IDLE;
         first_ff     <= 1'b1;
         fixed_ff     <= fts_pkg::FIXED_STEP_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         fixed_ff     <= fixed_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      now_ff      <= now_in;
      amount_ff   <= amount_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      ceil_ff     <= ceil_in;
      res_iter_ff <= res_iter_in;
      res_step_ff <= res_step_in;
      out_iter_ff <= out_iter_in;
      out_step_ff <= out_step_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      first_in     = first_ff;
      fixed_in     = fixed_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      amount_in    = amount_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      ceil_in      = ceil_ff;
      res_iter_in  = res_iter_ff;
      res_step_in  = res_step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_iter_in  = out_iter_ff;
      out_step_in  = out_step_ff;

      if (csr_wr_en) begin
         fixed_in = csr_wr_data;
      end

      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               now_in      = req_ch.current_time;
               res_iter_in = '0;
               res_step_in = '0;
               if (req_ch.command == fts_pkg::CMD_ADVANCE) begin
                  last_in  = last_ff + req_ch.advance_step;
                  state_in = fts_pkg::ST_FINISH;
               end else if (first_ff) begin
                  last_in  = req_ch.current_time;
                  first_in = 1'b0;
                  state_in = fts_pkg::ST_FINISH;
               end else begin
                  state_in = fts_pkg::ST_DIFF;
               end
            end
         end
         fts_pkg::ST_DIFF: begin
            // drop when the last update time is ahead of now
            if (time_diff[TW]) begin
               state_in = fts_pkg::ST_FINISH;
            end else begin
               amount_in = time_diff[TW-1:0];
               state_in  = fts_pkg::ST_CHECK;
            end
         end
         fts_pkg::ST_CHECK: begin
            if (amount_ff < f_eff) begin
               state_in = fts_pkg::ST_FINISH;
            end else begin
               quo_in   = amount_ff;
               rem_in   = '0;
               den_in   = f_eff;
               cnt_in   = '1;
               phase_in = fts_pkg::PH_FIXED;
               state_in = fts_pkg::ST_DIV;
            end
         end
         fts_pkg::ST_DIV: begin
            if (!rem_sub[TW]) begin
               rem_in = rem_sub[TW-1:0];
               quo_in = {quo_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[TW-1:0];
               quo_in = {quo_ff[TW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = fts_pkg::ST_CEIL;
            end
         end
         fts_pkg::ST_CEIL: begin
            ceil_in  = quo_ff + TW'(rem_ff != '0);
            state_in = fts_pkg::ST_NEXT;
         end
         fts_pkg::ST_NEXT: begin
            case (phase_ff)
               fts_pkg::PH_FIXED: begin
                  if (ceil_ff > MAX_DIV) begin
                     quo_in   = amount_ff;
                     rem_in   = '0;
                     den_in   = MAX_DIV;
                     cnt_in   = '1;
                     phase_in = fts_pkg::PH_MAX;
                     state_in = fts_pkg::ST_DIV;
                  end else begin
                     res_iter_in = ceil_ff[IW-1:0];
                     res_step_in = f_eff;
                     state_in    = fts_pkg::ST_FINISH;
                  end
               end
               fts_pkg::PH_MAX: begin
                  res_step_in = ceil_ff;
                  quo_in      = amount_ff;
                  rem_in      = '0;
                  den_in      = ceil_ff;
                  cnt_in      = '1;
                  phase_in    = fts_pkg::PH_STEP;
                  state_in    = fts_pkg::ST_DIV;
               end
               fts_pkg::PH_STEP: begin
                  res_iter_in = ceil_ff[IW-1:0];
                  state_in    = fts_pkg::ST_FINISH;
               end
               default: begin
                  state_in = fts_pkg::ST_FINISH;
               end
            endcase
         end
         fts_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_iter_in  = res_iter_ff;
               out_step_in  = res_step_ff;
               rsp_valid_in = 1'b1;
               state_in     = fts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fts_pkg::ST_IDLE;
         end
      endcase
   end

   a_iter_needs_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_iter_ff != '0) |-> (out_step_ff != '0))
      else $error("nonzero iterations with zero step");

   a_iter_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (MAX_UPDATES > 7) || (out_iter_ff <= IW'(MAX_UPDATES)))
      else $error("iterations above the update cap");

   a_advance_adds: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.command == fts_pkg::CMD_ADVANCE)
      |=> last_ff == $past(last_ff + req_ch.advance_step))
      else $error("advance did not add its step to the last update time");

   a_div_only_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fts_pkg::ST_DIV) && (cnt_ff != '0) |=> (state_ff == fts_pkg::ST_DIV))
      else $error("divider left before its last quotient bit");

endmodule
